/* design/bounded_byte_stream_fifo_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the bounded byte stream FIFO
// Shared concurrent checks, clocked on clk and held off during rst.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_BYTE_STREAM_FIFO_MACROS_SVH
`define BOUNDED_BYTE_STREAM_FIFO_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BBSF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BBSF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bbsf_pkg.sv */
// ---------------------------------------------------------------------------
// bbsf_pkg
// Types and fixed widths shared by the byte stream FIFO modules.
// ---------------------------------------------------------------------------
package bbsf_pkg;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 11;
  localparam int TOT_W  = 32;

  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_PEEK  = 2'd1,
    CMD_POP   = 2'd2,
    CMD_END   = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_PEEK = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [BYTE_W-1:0] write_byte;
    logic [CNT_W-1:0]  length;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] peek_byte;
    logic              byte_valid;
    logic              last;
    logic              accepted;
    logic [CNT_W-1:0]  stored_count;
    logic [CNT_W-1:0]  room_left;
    logic [TOT_W-1:0]  written_total;
    logic [TOT_W-1:0]  read_total;
    logic              stream_closed;
    logic              end_of_stream;
  } result_t;

  // Status handed from the controller to the result formatter.
  typedef struct packed {
    logic              strobe;
    logic              byte_valid;
    logic              last;
    logic              accepted;
    logic [CNT_W-1:0]  fill;
    logic [CNT_W-1:0]  eff_cap;
    logic [TOT_W-1:0]  wr_total;
    logic [TOT_W-1:0]  rd_total;
    logic              ended;
  } ctrl_stat_t;

endpackage

/* design/bbsf_ram.sv */
// ---------------------------------------------------------------------------
// bbsf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bbsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/bbsf_ctrl.sv */
// ---------------------------------------------------------------------------
// bbsf_ctrl
// Ring pointers, fill and totals, capacity register and peek sequencer.
// ---------------------------------------------------------------------------
`include "bounded_byte_stream_fifo_macros.svh"

module bbsf_ctrl
  import bbsf_pkg::*;
#(
  parameter int DEPTH    = 1024,
  parameter int PEEK_MAX = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [CNT_W-1:0]                       cfg_data,
  input  logic                                   start,
  input  item_t                                  item,
  output logic                                   busy,
  output ctrl_stat_t                             stat,
  output logic                                   ram_we,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_waddr,
  output logic [BYTE_W-1:0]                      ram_wdata,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_raddr
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
  localparam int RW = $clog2(PEEK_MAX + 1);
  localparam logic [CNT_W-1:0] CAP_LIMIT =
    (DEPTH >= (1 << CNT_W)) ? {CNT_W{1'b1}} : CNT_W'(DEPTH);

  state_t             state, state_next;
  logic [AW-1:0]      head, head_next;
  logic [CNT_W-1:0]   fill, fill_next;
  logic [TOT_W-1:0]   wr_total, wr_total_next;
  logic [TOT_W-1:0]   rd_total, rd_total_next;
  logic               ended, ended_next;
  logic [CNT_W-1:0]   cap;
  logic [AW-1:0]      rd_ptr, rd_ptr_next;
  logic [RW-1:0]      remaining, remaining_next;
  logic               strobe, strobe_next;
  logic               byte_valid, byte_valid_next;
  logic               last, last_next;
  logic               accepted, accepted_next;

  logic               accept;
  logic [CNT_W-1:0]   eff_cap;
  logic               room_ok;
  logic [CNT_W-1:0]   take;
  logic [RW-1:0]      peek_n;
  logic [AW-1:0]      tail;
  logic [AW-1:0]      head_pop;
  logic [AW-1:0]      head_inc;
  logic [AW-1:0]      ptr_inc;

  function automatic logic [AW-1:0] wrap_addr(input logic [SW-1:0] sum);
    logic [SW-1:0] adj;
    adj = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
    return adj[AW-1:0];
  endfunction

  assign accept   = start && (state == ST_IDLE);
  assign eff_cap  = (cap > CAP_LIMIT) ? CAP_LIMIT : cap;
  assign room_ok  = fill < eff_cap;
  assign take     = (item.length < fill) ? item.length : fill;
  assign peek_n   = (take > CNT_W'(PEEK_MAX)) ? RW'(PEEK_MAX) : RW'(take);
  assign tail     = wrap_addr(SW'(head) + SW'(fill));
  assign head_pop = wrap_addr(SW'(head) + SW'(take));
  assign head_inc = wrap_addr(SW'(head) + SW'(1));
  assign ptr_inc  = wrap_addr(SW'(rd_ptr) + SW'(1));

  assign busy      = (state == ST_PEEK);
  assign ram_we    = accept && (item.command == CMD_WRITE) && room_ok;
  assign ram_waddr = tail;
  assign ram_wdata = item.write_byte;
  // The head is read at the edge that takes a peek; later bytes follow rd_ptr.
  assign ram_raddr = (state == ST_IDLE) ? head : rd_ptr;

  always_comb begin
    state_next      = state;
    head_next       = head;
    fill_next       = fill;
    wr_total_next   = wr_total;
    rd_total_next   = rd_total;
    ended_next      = ended;
    rd_ptr_next     = rd_ptr;
    remaining_next  = remaining;
    strobe_next     = 1'b0;
    byte_valid_next = 1'b0;
    last_next       = 1'b1;
    accepted_next   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          unique case (item.command)
            CMD_WRITE: begin
              if (room_ok) begin
                fill_next     = fill + CNT_W'(1);
                wr_total_next = wr_total + TOT_W'(1);
                accepted_next = 1'b1;
              end
            end
            CMD_PEEK: begin
              if (peek_n != '0) begin
                byte_valid_next = 1'b1;
                last_next       = (peek_n == RW'(1));
                rd_ptr_next     = head_inc;
                remaining_next  = peek_n - RW'(1);
                if (peek_n != RW'(1)) begin
                  state_next = ST_PEEK;
                end
              end
            end
            CMD_POP: begin
              head_next     = head_pop;
              fill_next     = fill - take;
              rd_total_next = rd_total + TOT_W'(take);
            end
            CMD_END: begin
              ended_next = 1'b1;
            end
            default: begin
              ended_next = ended;
            end
          endcase
        end
      end
      ST_PEEK: begin
        // Stream one byte per cycle from the ring.
        strobe_next     = 1'b1;
        byte_valid_next = 1'b1;
        last_next       = (remaining == RW'(1));
        rd_ptr_next     = ptr_inc;
        remaining_next  = remaining - RW'(1);
        if (remaining == RW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      fill     <= '0;
      wr_total <= '0;
      rd_total <= '0;
      ended    <= 1'b0;
      cap      <= CAP_RESET;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      fill     <= fill_next;
      wr_total <= wr_total_next;
      rd_total <= rd_total_next;
      ended    <= ended_next;
      strobe   <= strobe_next;
      if (cfg_write) begin
        cap <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr     <= rd_ptr_next;
    remaining  <= remaining_next;
    byte_valid <= byte_valid_next;
    last       <= last_next;
    accepted   <= accepted_next;
  end

  assign stat = '{
    strobe:     strobe,
    byte_valid: byte_valid,
    last:       last,
    accepted:   accepted,
    fill:       fill,
    eff_cap:    eff_cap,
    wr_total:   wr_total,
    rd_total:   rd_total,
    ended:      ended
  };

  `BBSF_ASSERT_NOW(a_fill_bound, 1'b1, fill <= CAP_LIMIT, "fill exceeds ring depth")
  `BBSF_ASSERT_NEXT(a_peek_streams, state == ST_PEEK, strobe && byte_valid,
                    "peek cycle without a byte transaction")
  `BBSF_ASSERT_NOW(a_last_ends_item, strobe && last, state == ST_IDLE,
                   "final transaction while still streaming")
  `BBSF_ASSERT_NOW(a_more_follows, strobe && !last, state == ST_PEEK,
                   "non-final transaction with no peek in progress")
  `BBSF_ASSERT_NEXT(a_fill_held, state == ST_PEEK, $stable(fill),
                    "fill changed during a peek")

endmodule

/* design/bounded_byte_stream_fifo.sv */
// Every transaction's first result appears in the cycle after start is taken.
// Write, pop and end input give one result each; a peek gives max(1, n) results with
// n = min(length, fill, PEEK_MAX), one ring RAM byte per cycle.
// busy is high while a peek streams its later bytes; results cannot be stalled.
// Reset clears head, fill, totals and the ended flag and sets capacity to 1024;
// the ring RAM contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// bounded_byte_stream_fifo
// Bounded byte FIFO over a ring RAM with write, peek, pop and end input.
// ---------------------------------------------------------------------------
module bounded_byte_stream_fifo
  import bbsf_pkg::*;
#(
  parameter int DEPTH    = 1024,
  parameter int PEEK_MAX = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [CNT_W-1:0] cfg_data,
  input  logic             start,
  output logic             busy,
  input  item_t            item,
  output logic             strobe,
  output result_t          result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ctrl_stat_t        stat;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [CNT_W-1:0]  room;

  bbsf_ctrl #(
    .DEPTH    (DEPTH),
    .PEEK_MAX (PEEK_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .stat      (stat),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr)
  );

  bbsf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Floor room at zero when capacity was lowered below the fill.
  assign room = (stat.eff_cap > stat.fill) ? stat.eff_cap - stat.fill : '0;

  assign strobe = stat.strobe;

  assign result = '{
    peek_byte:     stat.byte_valid ? ram_rdata : '0,
    byte_valid:    stat.byte_valid,
    last:          stat.last,
    accepted:      stat.accepted,
    stored_count:  stat.fill,
    room_left:     room,
    written_total: stat.wr_total,
    read_total:    stat.rd_total,
    stream_closed: stat.ended,
    end_of_stream: (stat.fill == '0) && stat.ended
  };

endmodule
